// ===== hdl/dltq_pkg.sv =====
// ---------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants for the delta list timer queue.
// ---------------------------------------------------------------------------
`default_nettype none
package dltq_pkg;

	localparam int ENTRIES = 32;
	// Handle width: handles run 1..ENTRIES, 0 marks "none".
	localparam int HW = $clog2(ENTRIES + 1);
	// Entry index width: index = handle - 1.
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_MODIFY = 2'd1,
		OP_DELETE = 2'd2,
		OP_POLL   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_BADHDL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEL_CHECK,
		S_DEL_WALK,
		S_DEL_FIX,
		S_DEL_FREE,
		S_SET_TAKE,
		S_INS_WALK,
		S_INS_LINK,
		S_POLL,
		S_DONE
	} state_t;

	// One classified command handed from the front to the back.
	typedef struct packed {
		op_t           op;
		logic [31:0]   now_ms;
		logic [HW-1:0] handle;
		logic          hdl_zero;
		logic          hdl_in_range;
		logic [31:0]   duration_ms;
		logic [7:0]    event_sink;
		logic [31:0]   argument;
	} cmd_t;

	// Handshake between front and back.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	function automatic logic [IW-1:0] to_index(input logic [HW-1:0] h);
		logic [HW-1:0] t;
		t = h - HW'(1);
		return t[IW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/dltq_front.sv =====
// ---------------------------------------------------------------------------
// dltq_front
// Accepts input words, checks the handle and keeps a two-entry command queue.
// ---------------------------------------------------------------------------
`default_nettype none
module dltq_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [111:0]          in_data,
	output dltq_pkg::cmd_chan_t   cmd_out,
	input  wire                   cmd_ready
);

	dltq_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	dltq_pkg::cmd_t cmd_in;
	logic           push;
	logic           pop;

	// Unpack and classify the incoming word.
	always_comb begin
		cmd_in.op           = dltq_pkg::op_t'(in_data[1:0]);
		cmd_in.now_ms       = in_data[33:2];
		cmd_in.handle       = dltq_pkg::HW'(in_data[39:34]);
		cmd_in.hdl_zero     = (in_data[39:34] == 6'd0);
		cmd_in.hdl_in_range = (in_data[39:34] != 6'd0) &&
			(32'(in_data[39:34]) <= 32'(dltq_pkg::ENTRIES));
		cmd_in.duration_ms  = in_data[71:40];
		cmd_in.event_sink   = in_data[79:72];
		cmd_in.argument     = in_data[111:80];
	end

	assign in_ready      = (count_q != 2'd2);
	assign push          = in_valid && in_ready;
	assign pop           = cmd_out.valid && cmd_ready;
	assign cmd_out.valid = (count_q != 2'd0);
	assign cmd_out.cmd   = slot_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cmd_in;
	end

endmodule
`default_nettype wire

// ===== hdl/dltq_back.sv =====
// ---------------------------------------------------------------------------
// dltq_back
// Runs each command over the entry pool: list walks, free list, result word.
// ---------------------------------------------------------------------------
`default_nettype none
module dltq_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire dltq_pkg::cmd_chan_t cmd_in,
	output logic                 cmd_ready,
	output logic                 res_valid,
	input  wire                  res_ready,
	output logic [63:0]          res_data
);

	localparam int HW = dltq_pkg::HW;
	localparam int IW = dltq_pkg::IW;

	dltq_pkg::state_t state_q, state_nx;
	dltq_pkg::cmd_t   cmd_q;

	logic [HW-1:0] next_q  [dltq_pkg::ENTRIES];
	logic [31:0]   delta_q [dltq_pkg::ENTRIES];
	logic [7:0]    sink_q  [dltq_pkg::ENTRIES];
	logic [31:0]   arg_q   [dltq_pkg::ENTRIES];
	logic [dltq_pkg::ENTRIES-1:0] alloc_q;

	logic [HW-1:0] head_q, free_head_q, free_cnt_q, min_free_q;
	logic [31:0]   base_q;

	// Walk registers.
	logic [HW-1:0] cur_q, prev_q, nh_q, nx_q;
	logic [HW-1:0] steps_q;
	logic [31:0]   d_q, hdelta_q;

	// Result fields.
	dltq_pkg::status_t status_q;
	logic          exp_q;
	logic [HW-1:0] eh_q;
	logic [7:0]    es_q;
	logic [31:0]   ea_q;
	logic [63:0]   res_q;
	logic          res_valid_q;

	logic [IW-1:0] cur_i, hdl_i, free_i, nx_i, head_i;
	logic [31:0]   cur_delta, elapsed;
	logic [HW-1:0] cur_next;
	logic          walk_end, out_free;

	assign cur_i     = dltq_pkg::to_index(cur_q);
	assign hdl_i     = dltq_pkg::to_index(cmd_q.handle);
	assign free_i    = dltq_pkg::to_index(free_head_q);
	assign nx_i      = dltq_pkg::to_index(nx_q);
	assign head_i    = dltq_pkg::to_index(head_q);
	assign cur_delta = delta_q[cur_i];
	assign cur_next  = next_q[cur_i];
	assign walk_end  = (cur_q == '0) || (steps_q == HW'(dltq_pkg::ENTRIES));
	assign elapsed   = cmd_q.now_ms - base_q;
	assign out_free  = !res_valid_q || res_ready;

	assign cmd_ready = (state_q == dltq_pkg::S_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dltq_pkg::S_IDLE: begin
				if (cmd_in.valid) begin
					case (cmd_in.cmd.op)
						dltq_pkg::OP_SET:  state_nx = dltq_pkg::S_SET_TAKE;
						dltq_pkg::OP_POLL: state_nx = dltq_pkg::S_POLL;
						default:           state_nx = dltq_pkg::S_DEL_CHECK;
					endcase
				end
			end
			dltq_pkg::S_DEL_CHECK: begin
				if (cmd_q.hdl_zero)
					state_nx = (cmd_q.op == dltq_pkg::OP_MODIFY) ?
						dltq_pkg::S_SET_TAKE : dltq_pkg::S_DONE;
				else if (!cmd_q.hdl_in_range || !alloc_q[hdl_i])
					state_nx = dltq_pkg::S_DONE;
				else
					state_nx = dltq_pkg::S_DEL_WALK;
			end
			dltq_pkg::S_DEL_WALK: begin
				if (walk_end) state_nx = dltq_pkg::S_DEL_FREE;
				else if (cur_q == cmd_q.handle) state_nx = dltq_pkg::S_DEL_FIX;
			end
			dltq_pkg::S_DEL_FIX: state_nx = dltq_pkg::S_DEL_FREE;
			dltq_pkg::S_DEL_FREE: begin
				state_nx = (cmd_q.op == dltq_pkg::OP_MODIFY) ?
					dltq_pkg::S_SET_TAKE : dltq_pkg::S_DONE;
			end
			dltq_pkg::S_SET_TAKE: begin
				state_nx = (free_head_q == '0) ? dltq_pkg::S_DONE : dltq_pkg::S_INS_WALK;
			end
			dltq_pkg::S_INS_WALK: begin
				if (walk_end || cur_delta > d_q) state_nx = dltq_pkg::S_INS_LINK;
			end
			dltq_pkg::S_INS_LINK: state_nx = dltq_pkg::S_DONE;
			dltq_pkg::S_POLL:     state_nx = dltq_pkg::S_DONE;
			dltq_pkg::S_DONE: begin
				if (out_free) state_nx = dltq_pkg::S_IDLE;
			end
			default: state_nx = dltq_pkg::S_IDLE;
		endcase
	end

	// Control registers and list heads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dltq_pkg::S_IDLE;
			alloc_q     <= '0;
			head_q      <= '0;
			free_head_q <= HW'(1);
			free_cnt_q  <= HW'(dltq_pkg::ENTRIES);
			min_free_q  <= HW'(dltq_pkg::ENTRIES);
			base_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < dltq_pkg::ENTRIES; i++)
				next_q[i] <= (i < dltq_pkg::ENTRIES - 1) ? HW'(i + 2) : '0;
		end else begin
			state_q <= state_nx;
			// A result is loaded in the done state once the output is free.
			if (state_q == dltq_pkg::S_DONE && out_free) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			case (state_q)
				dltq_pkg::S_DEL_WALK: begin
					if (!walk_end && cur_q == cmd_q.handle) begin
						if (prev_q == '0) head_q <= cur_next;
						else next_q[dltq_pkg::to_index(prev_q)] <= cur_next;
					end
				end
				dltq_pkg::S_DEL_FREE: begin
					next_q[hdl_i]  <= free_head_q;
					free_head_q    <= cmd_q.handle;
					alloc_q[hdl_i] <= 1'b0;
					free_cnt_q     <= free_cnt_q + HW'(1);
				end
				dltq_pkg::S_SET_TAKE: begin
					if (free_head_q != '0) begin
						free_head_q     <= next_q[free_i];
						free_cnt_q      <= free_cnt_q - HW'(1);
						if (min_free_q > free_cnt_q - HW'(1))
							min_free_q <= free_cnt_q - HW'(1);
						alloc_q[free_i] <= 1'b1;
					end
				end
				dltq_pkg::S_INS_LINK: begin
					next_q[dltq_pkg::to_index(nh_q)] <= cur_q;
					if (prev_q == '0) head_q <= nh_q;
					else next_q[dltq_pkg::to_index(prev_q)] <= nh_q;
				end
				dltq_pkg::S_POLL: begin
					if (head_q != '0 && elapsed >= delta_q[head_i]) begin
						head_q <= next_q[head_i];
						base_q <= base_q + delta_q[head_i];
					end
				end
				default: ;
			endcase
		end
	end

	// Payload: command, walk registers, entry data and result word.
	always_ff @(posedge clk) begin
		case (state_q)
			dltq_pkg::S_IDLE: begin
				cmd_q    <= cmd_in.cmd;
				status_q <= dltq_pkg::ST_OK;
				nh_q     <= '0;
				exp_q    <= 1'b0;
				eh_q     <= '0;
				es_q     <= '0;
				ea_q     <= '0;
				cur_q    <= head_q;
				prev_q   <= '0;
				steps_q  <= '0;
			end
			dltq_pkg::S_DEL_CHECK: begin
				if (!cmd_q.hdl_zero && (!cmd_q.hdl_in_range || !alloc_q[hdl_i]))
					status_q <= dltq_pkg::ST_BADHDL;
				cur_q   <= head_q;
				prev_q  <= '0;
				steps_q <= '0;
			end
			dltq_pkg::S_DEL_WALK: begin
				nx_q     <= cur_next;
				hdelta_q <= cur_delta;
				prev_q   <= cur_q;
				cur_q    <= cur_next;
				steps_q  <= steps_q + HW'(1);
			end
			dltq_pkg::S_DEL_FIX: begin
				if (nx_q != '0) delta_q[nx_i] <= delta_q[nx_i] + hdelta_q;
			end
			dltq_pkg::S_SET_TAKE: begin
				cur_q   <= head_q;
				prev_q  <= '0;
				steps_q <= '0;
				d_q     <= (cmd_q.now_ms - base_q) + cmd_q.duration_ms;
				if (free_head_q == '0) begin
					status_q <= dltq_pkg::ST_NOFREE;
				end else begin
					nh_q           <= free_head_q;
					sink_q[free_i] <= cmd_q.event_sink;
					arg_q[free_i]  <= cmd_q.argument;
				end
			end
			dltq_pkg::S_INS_WALK: begin
				if (!walk_end) begin
					if (cur_delta > d_q) begin
						delta_q[cur_i] <= cur_delta - d_q;
					end else begin
						d_q     <= d_q - cur_delta;
						prev_q  <= cur_q;
						cur_q   <= cur_next;
						steps_q <= steps_q + HW'(1);
					end
				end
			end
			dltq_pkg::S_INS_LINK: begin
				delta_q[dltq_pkg::to_index(nh_q)] <= d_q;
			end
			dltq_pkg::S_POLL: begin
				if (head_q != '0 && elapsed >= delta_q[head_i]) begin
					exp_q <= 1'b1;
					eh_q  <= head_q;
					es_q  <= sink_q[head_i];
					ea_q  <= arg_q[head_i];
				end
			end
			dltq_pkg::S_DONE: begin
				if (out_free)
					res_q <= {3'b000, 6'(min_free_q), ea_q, es_q, 6'(eh_q), exp_q,
						6'(nh_q), status_q};
			end
			default: ;
		endcase
	end

	// Pool accounting never leaves its range.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= HW'(dltq_pkg::ENTRIES))
		else $error("free count above pool size");

	a_min_le_free: assert property (@(posedge clk) disable iff (!arst_n)
		min_free_q <= free_cnt_q)
		else $error("low-water mark above free count");

	// An empty free list always goes with a zero free count.
	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == '0) |-> (free_cnt_q == '0))
		else $error("free list empty with nonzero count");

	// A new result is only loaded once the previous one has been taken.
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> $stable(res_q))
		else $error("result word changed while stalled");

endmodule
`default_nettype wire

// ===== hdl/delta_list_timer_queue.sv =====
// Flow: an accepted word's result follows the list engine's pass; poll reads only the
// list head, set and delete walk the list, modify deletes (nonzero handle) and then sets.
// Throughput: one word at a time in the list engine, one list link per cycle; the
// next word is taken in the cycle after a result is loaded; a two-word queue absorbs bursts.
// Reset: arst_n clears the pool at once, no clearing pass is needed.
// ---------------------------------------------------------------------------
// delta_list_timer_queue
// Timer pool kept as a sorted delta list with a free list, stream ports.
// ---------------------------------------------------------------------------
`default_nettype none
module delta_list_timer_queue (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// op[1:0], now_ms[33:2], handle[39:34], duration_ms[71:40],
	// event_sink[79:72], argument[111:80]
	input  wire  [111:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// status[1:0], new_handle[7:2], expired[8], expired_handle[14:9],
	// expired_sink[22:15], expired_argument[54:23], min_free[60:55], zero[63:61]
	output logic [63:0]  m_tdata
);

	dltq_pkg::cmd_chan_t cmd;
	logic                cmd_ready;

	dltq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.cmd_out   (cmd),
		.cmd_ready (cmd_ready)
	);

	dltq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd),
		.cmd_ready (cmd_ready),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata)
	);

endmodule
`default_nettype wire
